/* src/dpim_pkg.sv */
// Package for the dipole potential unit: item types, stage payloads and codes.
// Depends on nothing; every other file of the unit refers to it by scoped names.
package dpim_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic signed [31:0] moment_x;
    logic signed [31:0] moment_y;
    logic signed [31:0] moment_z;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] potential;
    logic [1:0]         status;
  } out_item_t;

  // Payload of one square-root cell.
  typedef struct packed {
    logic [65:0] s;
    logic [64:0] pmag;
    logic        neg;
    logic        zero;
    logic [64:0] rem;
    logic [62:0] root;
  } sqrt_t;

  // Payload of one divider cell.
  typedef struct packed {
    logic [128:0] d;
    logic [128:0] rem;
    logic [63:0]  q;
    logic         neg;
    logic         zero;
    logic         sat;
  } div_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_COINCIDENT = 2'd1;
  localparam logic [1:0] ST_SATURATED  = 2'd2;

  localparam logic [31:0] SCALE_RESET = 32'd15802;
  localparam logic [63:0] POT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] POT_MIN = 64'h8000_0000_0000_0000;

endpackage

/* src/dpim_front.sv */
// Front stages: differences, magnitudes, products, sums and the dot product sign.
// Depends on dpim_pkg.
module dpim_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  dpim_pkg::in_item_t in_item,
  output logic              out_valid,
  output dpim_pkg::sqrt_t   out_data
);

  logic signed [31:0] pt [3];
  logic signed [31:0] sr [3];
  logic signed [31:0] mo [3];

  logic [32:0] ad_r [3], ad_nxt [3];
  logic [31:0] am_r [3], am_nxt [3];
  logic [2:0]  sg_r, sg_nxt;
  logic [65:0] sq_r [3];
  logic [64:0] pr_r [3];
  logic [2:0]  sg2_r;
  logic [65:0] s_r, s_nxt;
  logic [64:0] pos_r, pos_nxt, neg_r, neg_nxt;
  logic        v1_r, v2_r, v3_r, v4_r;
  dpim_pkg::sqrt_t o_r, o_nxt;

  assign pt[0] = in_item.point_x;
  assign pt[1] = in_item.point_y;
  assign pt[2] = in_item.point_z;
  assign sr[0] = in_item.source_x;
  assign sr[1] = in_item.source_y;
  assign sr[2] = in_item.source_z;
  assign mo[0] = in_item.moment_x;
  assign mo[1] = in_item.moment_y;
  assign mo[2] = in_item.moment_z;

  always_comb begin
    logic signed [32:0] d;
    for (int k = 0; k < 3; k++) begin
      d = {pt[k][31], pt[k]} - {sr[k][31], sr[k]};
      ad_nxt[k] = d[32] ? 33'(-d) : 33'(d);
      am_nxt[k] = mo[k][31] ? 32'(-mo[k]) : 32'(mo[k]);
      sg_nxt[k] = d[32] ^ mo[k][31];
    end
  end

  always_comb begin
    s_nxt   = '0;
    pos_nxt = '0;
    neg_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      s_nxt = s_nxt + sq_r[k];
      if (sg2_r[k]) begin
        neg_nxt = neg_nxt + pr_r[k];
      end else begin
        pos_nxt = pos_nxt + pr_r[k];
      end
    end
  end

  always_comb begin
    o_nxt      = '0;
    o_nxt.s    = s_r;
    o_nxt.neg  = pos_r < neg_r;
    o_nxt.pmag = (pos_r < neg_r) ? (neg_r - pos_r) : (pos_r - neg_r);
    o_nxt.zero = (s_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ad_r[k] <= ad_nxt[k];
        am_r[k] <= am_nxt[k];
        sq_r[k] <= 66'(ad_r[k]) * 66'(ad_r[k]);
        pr_r[k] <= 65'(ad_r[k]) * 65'(am_r[k]);
      end
      sg_r  <= sg_nxt;
      sg2_r <= sg_r;
      s_r   <= s_nxt;
      pos_r <= pos_nxt;
      neg_r <= neg_nxt;
      o_r   <= o_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = o_r;

endmodule

/* src/dpim_sqrt_cell.sv */
// One cell of the square-root chain: settles one root bit from two radicand bits.
// Depends on dpim_pkg.
module dpim_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  dpim_pkg::sqrt_t in_data,
  input  logic [1:0]      digit,
  output logic            out_valid,
  output dpim_pkg::sqrt_t out_data
);

  logic            v_r;
  dpim_pkg::sqrt_t d_r, d_nxt;

  always_comb begin
    logic [66:0] cur;
    logic [66:0] trial;
    cur   = {in_data.rem, digit};
    trial = {2'b00, in_data.root, 2'b01};
    d_nxt = in_data;
    if (cur >= trial) begin
      d_nxt.rem  = 65'(cur - trial);
      d_nxt.root = {in_data.root[61:0], 1'b1};
    end else begin
      d_nxt.rem  = cur[64:0];
      d_nxt.root = {in_data.root[61:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

/* src/dpim_mul.sv */
// Three-stage multiplier: denominator S*R and numerator scale*|P| from 32-bit partials.
// Depends on dpim_pkg.
module dpim_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic [31:0]     scale,
  input  logic            in_valid,
  input  dpim_pkg::sqrt_t in_data,
  output logic            out_valid,
  output dpim_pkg::div_t  out_data
);

  logic [63:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [33:0] pp20_r;
  logic [32:0] pp21_r;
  logic [63:0] sp0_r, sp1_r;
  logic [31:0] sp2_r;
  logic [128:0] x1_r, x2_r;
  logic [96:0]  n_r;
  logic [1:0]   neg_r, zero_r;
  logic         va_r, vb_r, vc_r;
  dpim_pkg::div_t o_r, o_nxt;

  always_comb begin
    logic [128:0] dd;
    logic [128:0] n4;
    dd      = x1_r + x2_r;
    n4      = 129'({n_r, 2'b00});
    o_nxt   = '0;
    o_nxt.d = dd;
    o_nxt.sat  = (n4 >= dd);
    o_nxt.rem  = (n4 >= dd) ? '0 : n4;
    o_nxt.neg  = neg_r[1];
    o_nxt.zero = zero_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= 64'(in_data.s[31:0]) * 64'(in_data.root[31:0]);
      pp01_r <= 64'(in_data.s[31:0]) * 64'(in_data.root[62:32]);
      pp10_r <= 64'(in_data.s[63:32]) * 64'(in_data.root[31:0]);
      pp11_r <= 64'(in_data.s[63:32]) * 64'(in_data.root[62:32]);
      pp20_r <= 34'(in_data.s[65:64]) * 34'(in_data.root[31:0]);
      pp21_r <= 33'(in_data.s[65:64]) * 33'(in_data.root[62:32]);
      sp0_r  <= 64'(scale) * 64'(in_data.pmag[31:0]);
      sp1_r  <= 64'(scale) * 64'(in_data.pmag[63:32]);
      sp2_r  <= in_data.pmag[64] ? scale : '0;
      neg_r[0]  <= in_data.neg;
      zero_r[0] <= in_data.zero;

      x1_r <= 129'(pp00_r) + (129'(pp01_r) << 32) + (129'(pp10_r) << 32);
      x2_r <= (129'(pp11_r) << 64) + (129'(pp20_r) << 64) + (129'(pp21_r) << 96);
      n_r  <= 97'(sp0_r) + (97'(sp1_r) << 32) + (97'(sp2_r) << 64);
      neg_r[1]  <= neg_r[0];
      zero_r[1] <= zero_r[0];

      o_r <= o_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_data  = o_r;

endmodule

/* src/dpim_div_cell.sv */
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on dpim_pkg.
module dpim_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  dpim_pkg::div_t in_data,
  output logic           out_valid,
  output dpim_pkg::div_t out_data
);

  logic           v_r;
  dpim_pkg::div_t d_r, d_nxt;

  always_comb begin
    logic [129:0] two;
    two   = {in_data.rem, 1'b0};
    d_nxt = in_data;
    if (two >= {1'b0, in_data.d}) begin
      d_nxt.rem = 129'(two - {1'b0, in_data.d});
      d_nxt.q   = {in_data.q[62:0], 1'b1};
    end else begin
      d_nxt.rem = two[128:0];
      d_nxt.q   = {in_data.q[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

/* src/dipole_potential_infinite_medium_unit.sv */
// Top level of the dipole potential unit: front stages, square-root chain,
// multiplier, divider chain and output register. Depends on dpim_pkg and all cells.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   dpim_pkg::in_item_t
//   out_      output     out_valid / out_stall dpim_pkg::out_item_t
//   cfg_      input      cfg_wr_en             32-bit scale, unsigned Q16.16
//
// The unit takes one item every cycle while in_stall is low. A result reaches the
// output register through four front stages, 63 square-root cells (one root bit
// each), three multiplier stages and 64 divider cells (one quotient bit each).
// Reset (synchronous, active low) empties the pipeline and loads the scale of 15802.
// When a result waits in the output register, the pipeline keeps moving and
// taking items until a finished item reaches its last cell; only then does it stall.
module dipole_potential_infinite_medium_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dpim_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dpim_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);

  logic [31:0] scale_r;

  // The whole chain advances together. It holds only when the last divider cell
  // has an item and the output register cannot take it.
  logic out_free;
  logic en;

  logic            sq_v [0:63];
  dpim_pkg::sqrt_t sq_d [0:63];
  logic [1:0]      dig  [0:62];
  logic            dv_v [0:64];
  dpim_pkg::div_t  dv_d [0:64];

  logic                out_valid_r;
  dpim_pkg::out_item_t out_item_r, out_item_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign en       = out_free || !dv_v[64];
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= dpim_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  dpim_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (sq_v[0]),
    .out_data  (sq_d[0])
  );

  // Square-root chain. The radicand is S shifted left by 60, so the lowest 30
  // digit pairs are zero and the rest come straight out of S.
  for (genvar k = 0; k < 63; k++) begin : g_sqrt
    localparam int I = 62 - k;
    if (I >= 30) begin : g_dig
      assign dig[k] = sq_d[k].s[2*I-59 : 2*I-60];
    end else begin : g_zero
      assign dig[k] = 2'b00;
    end
    dpim_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[k]),
      .in_data   (sq_d[k]),
      .digit     (dig[k]),
      .out_valid (sq_v[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  dpim_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .scale     (scale_r),
    .in_valid  (sq_v[63]),
    .in_data   (sq_d[63]),
    .out_valid (dv_v[0]),
    .out_data  (dv_d[0])
  );

  // Divider chain: the numerator scale*|P|*2^66 over S*R, one quotient bit a cell.
  for (genvar k = 0; k < 64; k++) begin : g_div
    dpim_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_v[k]),
      .in_data   (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_data  (dv_d[k+1])
    );
  end

  // Final sign, saturation and the coincident-point case.
  always_comb begin
    logic over;
    over = dv_d[64].neg ? (dv_d[64].q > dpim_pkg::POT_MIN)
                        : (dv_d[64].q > dpim_pkg::POT_MAX);
    if (dv_d[64].zero) begin
      out_item_nxt.potential = '0;
      out_item_nxt.status    = dpim_pkg::ST_COINCIDENT;
    end else if (dv_d[64].sat || over) begin
      out_item_nxt.potential = dv_d[64].neg ? dpim_pkg::POT_MIN : dpim_pkg::POT_MAX;
      out_item_nxt.status    = dpim_pkg::ST_SATURATED;
    end else begin
      out_item_nxt.potential = dv_d[64].neg ? -dv_d[64].q : dv_d[64].q;
      out_item_nxt.status    = dpim_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= dv_v[64];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* src/dpim_checker.sv */
// Port-level checks for the dipole potential unit, and the bind that attaches them.
// Depends on dpim_pkg and dipole_potential_infinite_medium_unit.
module dpim_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dpim_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input dpim_pkg::out_item_t out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == dpim_pkg::ST_COINCIDENT |-> out_item.potential == '0)
    else $error("coincident point gave a nonzero potential");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == dpim_pkg::ST_SATURATED |->
      out_item.potential == dpim_pkg::POT_MAX || out_item.potential == dpim_pkg::POT_MIN)
    else $error("saturated result is not a limit value");

endmodule

bind dipole_potential_infinite_medium_unit dpim_checker u_dpim_checker (.*);
